// ----- hdl/rpn_pkg.sv -----
// ----------------------------------------------------------------------------
// RPN calculator package
// Item types, status codes, microcode format and the microprogram of the
// Q16.16 reverse Polish stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int DATA_W          = 32;
    localparam int DEPTH_W         = 7;
    localparam int OP_W            = 4;
    localparam int FRAC_W          = 16;
    localparam int INT_W           = 16;
    localparam int DIV_W           = 48;
    localparam int DIV_ITER_W      = 6;
    localparam int UPC_W           = 6;
    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [DIV_ITER_W-1:0] DIV_ITERS_M1 = DIV_ITER_W'(DIV_W - 1);
    localparam logic [DIV_ITER_W-1:0] MOD_ITERS_M1 = DIV_ITER_W'(INT_W - 1);

    localparam logic [OP_W-1:0] OP_PUSH   = 4'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 4'd1;
    localparam logic [OP_W-1:0] OP_SUB    = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL    = 4'd3;
    localparam logic [OP_W-1:0] OP_DIV    = 4'd4;
    localparam logic [OP_W-1:0] OP_MOD    = 4'd5;
    localparam logic [OP_W-1:0] OP_PRINT  = 4'd6;
    localparam logic [OP_W-1:0] OP_EQUALS = 4'd7;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNDER   = 3'd1,
        ST_FULL    = 3'd2,
        ST_ZDIV    = 3'd3,
        ST_UNKNOWN = 3'd4,
        ST_SAT     = 3'd5
    } status_t;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic signed [DATA_W-1:0] operand;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        status_t                  status;
        logic [DEPTH_W-1:0]       depth;
        logic                     last;
    } rsp_t;

    typedef enum logic [4:0] {
        U_NOP,
        U_PUSH_IN,
        U_POP_B,
        U_POP_A,
        U_ADD,
        U_SUB,
        U_MUL,
        U_MUL_SCALE,
        U_CHK_DIV,
        U_CHK_MOD,
        U_DIV_LOAD,
        U_MOD_LOAD,
        U_DIV_STEP,
        U_DIV_FIX,
        U_MOD_FIX,
        U_PUSH_RES,
        U_MOV_B,
        U_UNKNOWN,
        U_EMIT,
        U_PR_LOAD,
        U_PR_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ZDIV,
        C_ZMOD,
        C_LOOP,
        C_PR_EMPTY,
        C_PR_MORE
    } ucond_t;

    typedef struct packed {
        uop_t             uop;
        ucond_t           cond;
        logic [UPC_W-1:0] target;
        logic             fin;
        logic             rd_idx;
    } uctl_t;

    // Program entry points and loop labels.
    localparam logic [UPC_W-1:0] A_PUSH     = 6'd0;
    localparam logic [UPC_W-1:0] A_EMIT_END = 6'd1;
    localparam logic [UPC_W-1:0] A_UNKNOWN  = 6'd2;
    localparam logic [UPC_W-1:0] A_PRINT    = 6'd4;
    localparam logic [UPC_W-1:0] A_PR_READ  = 6'd5;
    localparam logic [UPC_W-1:0] A_PR_DONE  = 6'd7;
    localparam logic [UPC_W-1:0] A_EQUALS   = 6'd8;
    localparam logic [UPC_W-1:0] A_ADD      = 6'd12;
    localparam logic [UPC_W-1:0] A_SUB      = 6'd19;
    localparam logic [UPC_W-1:0] A_MUL      = 6'd26;
    localparam logic [UPC_W-1:0] A_DIV      = 6'd34;
    localparam logic [UPC_W-1:0] A_DIV_LOOP = 6'd39;
    localparam logic [UPC_W-1:0] A_MOD      = 6'd43;
    localparam logic [UPC_W-1:0] A_MOD_LOOP = 6'd48;

    function automatic uctl_t uw(input uop_t u, input ucond_t c,
                                 input logic [UPC_W-1:0] t,
                                 input logic f, input logic r);
        uctl_t w;
        w.uop    = u;
        w.cond   = c;
        w.target = t;
        w.fin    = f;
        w.rd_idx = r;
        return w;
    endfunction

    function automatic logic [UPC_W-1:0] entry(input logic [OP_W-1:0] op);
        logic [UPC_W-1:0] a;
        case (op)
            OP_PUSH:   a = A_PUSH;
            OP_ADD:    a = A_ADD;
            OP_SUB:    a = A_SUB;
            OP_MUL:    a = A_MUL;
            OP_DIV:    a = A_DIV;
            OP_MOD:    a = A_MOD;
            OP_PRINT:  a = A_PRINT;
            OP_EQUALS: a = A_EQUALS;
            default:   a = A_UNKNOWN;
        endcase
        return a;
    endfunction

    // Every pop is preceded by a step that reads the stack top, since the
    // stack memory delivers its read data from a register.
    function automatic uctl_t ucode(input logic [UPC_W-1:0] addr);
        uctl_t w;
        case (addr)
            A_PUSH:           w = uw(U_PUSH_IN,   C_NEXT,     '0,         1'b0, 1'b0);
            A_EMIT_END:       w = uw(U_EMIT,      C_NEXT,     '0,         1'b1, 1'b0);
            A_UNKNOWN:        w = uw(U_UNKNOWN,   C_NEXT,     '0,         1'b0, 1'b0);
            A_UNKNOWN + 6'd1: w = uw(U_EMIT,      C_NEXT,     '0,         1'b1, 1'b0);
            A_PRINT:          w = uw(U_PR_LOAD,   C_NEXT,     '0,         1'b0, 1'b0);
            A_PR_READ:        w = uw(U_NOP,       C_PR_EMPTY, A_PR_DONE,  1'b0, 1'b1);
            A_PR_READ + 6'd1: w = uw(U_PR_EMIT,   C_PR_MORE,  A_PR_READ,  1'b1, 1'b0);
            A_PR_DONE:        w = uw(U_NOP,       C_NEXT,     '0,         1'b1, 1'b0);
            A_EQUALS:         w = uw(U_NOP,       C_NEXT,     '0,         1'b0, 1'b0);
            A_EQUALS + 6'd1:  w = uw(U_POP_B,     C_NEXT,     '0,         1'b0, 1'b0);
            A_EQUALS + 6'd2:  w = uw(U_MOV_B,     C_NEXT,     '0,         1'b0, 1'b0);
            A_EQUALS + 6'd3:  w = uw(U_EMIT,      C_NEXT,     '0,         1'b1, 1'b0);
            A_ADD:            w = uw(U_NOP,       C_NEXT,     '0,         1'b0, 1'b0);
            A_ADD + 6'd1:     w = uw(U_POP_B,     C_NEXT,     '0,         1'b0, 1'b0);
            A_ADD + 6'd2:     w = uw(U_NOP,       C_NEXT,     '0,         1'b0, 1'b0);
            A_ADD + 6'd3:     w = uw(U_POP_A,     C_NEXT,     '0,         1'b0, 1'b0);
            A_ADD + 6'd4:     w = uw(U_ADD,       C_NEXT,     '0,         1'b0, 1'b0);
            A_ADD + 6'd5:     w = uw(U_PUSH_RES,  C_NEXT,     '0,         1'b0, 1'b0);
            A_ADD + 6'd6:     w = uw(U_EMIT,      C_NEXT,     '0,         1'b1, 1'b0);
            A_SUB:            w = uw(U_NOP,       C_NEXT,     '0,         1'b0, 1'b0);
            A_SUB + 6'd1:     w = uw(U_POP_B,     C_NEXT,     '0,         1'b0, 1'b0);
            A_SUB + 6'd2:     w = uw(U_NOP,       C_NEXT,     '0,         1'b0, 1'b0);
            A_SUB + 6'd3:     w = uw(U_POP_A,     C_NEXT,     '0,         1'b0, 1'b0);
            A_SUB + 6'd4:     w = uw(U_SUB,       C_NEXT,     '0,         1'b0, 1'b0);
            A_SUB + 6'd5:     w = uw(U_PUSH_RES,  C_NEXT,     '0,         1'b0, 1'b0);
            A_SUB + 6'd6:     w = uw(U_EMIT,      C_NEXT,     '0,         1'b1, 1'b0);
            A_MUL:            w = uw(U_NOP,       C_NEXT,     '0,         1'b0, 1'b0);
            A_MUL + 6'd1:     w = uw(U_POP_B,     C_NEXT,     '0,         1'b0, 1'b0);
            A_MUL + 6'd2:     w = uw(U_NOP,       C_NEXT,     '0,         1'b0, 1'b0);
            A_MUL + 6'd3:     w = uw(U_POP_A,     C_NEXT,     '0,         1'b0, 1'b0);
            A_MUL + 6'd4:     w = uw(U_MUL,       C_NEXT,     '0,         1'b0, 1'b0);
            A_MUL + 6'd5:     w = uw(U_MUL_SCALE, C_NEXT,     '0,         1'b0, 1'b0);
            A_MUL + 6'd6:     w = uw(U_PUSH_RES,  C_NEXT,     '0,         1'b0, 1'b0);
            A_MUL + 6'd7:     w = uw(U_EMIT,      C_NEXT,     '0,         1'b1, 1'b0);
            A_DIV:            w = uw(U_NOP,       C_NEXT,     '0,         1'b0, 1'b0);
            A_DIV + 6'd1:     w = uw(U_POP_B,     C_NEXT,     '0,         1'b0, 1'b0);
            A_DIV + 6'd2:     w = uw(U_CHK_DIV,   C_ZDIV,     A_EMIT_END, 1'b0, 1'b0);
            A_DIV + 6'd3:     w = uw(U_POP_A,     C_NEXT,     '0,         1'b0, 1'b0);
            A_DIV + 6'd4:     w = uw(U_DIV_LOAD,  C_NEXT,     '0,         1'b0, 1'b0);
            A_DIV_LOOP:       w = uw(U_DIV_STEP,  C_LOOP,     A_DIV_LOOP, 1'b0, 1'b0);
            A_DIV_LOOP + 6'd1: w = uw(U_DIV_FIX,  C_NEXT,     '0,         1'b0, 1'b0);
            A_DIV_LOOP + 6'd2: w = uw(U_PUSH_RES, C_NEXT,     '0,         1'b0, 1'b0);
            A_DIV_LOOP + 6'd3: w = uw(U_EMIT,     C_NEXT,     '0,         1'b1, 1'b0);
            A_MOD:            w = uw(U_NOP,       C_NEXT,     '0,         1'b0, 1'b0);
            A_MOD + 6'd1:     w = uw(U_POP_B,     C_NEXT,     '0,         1'b0, 1'b0);
            A_MOD + 6'd2:     w = uw(U_CHK_MOD,   C_ZMOD,     A_EMIT_END, 1'b0, 1'b0);
            A_MOD + 6'd3:     w = uw(U_POP_A,     C_NEXT,     '0,         1'b0, 1'b0);
            A_MOD + 6'd4:     w = uw(U_MOD_LOAD,  C_NEXT,     '0,         1'b0, 1'b0);
            A_MOD_LOOP:       w = uw(U_DIV_STEP,  C_LOOP,     A_MOD_LOOP, 1'b0, 1'b0);
            A_MOD_LOOP + 6'd1: w = uw(U_MOD_FIX,  C_NEXT,     '0,         1'b0, 1'b0);
            A_MOD_LOOP + 6'd2: w = uw(U_PUSH_RES, C_NEXT,     '0,         1'b0, 1'b0);
            A_MOD_LOOP + 6'd3: w = uw(U_EMIT,     C_NEXT,     '0,         1'b1, 1'b0);
            default:          w = uw(U_NOP,       C_NEXT,     '0,         1'b1, 1'b0);
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/rpn_stack_calculator_core.sv -----
// ----------------------------------------------------------------------------
// RPN stack calculator core
// Microcoded Q16.16 reverse Polish calculator with an on-chip value stack.
// ----------------------------------------------------------------------------
// An item on command is taken at a rising edge where start is high and busy
// is low; busy then stays high until the item's microprogram has finished.
// Results leave on result, each for exactly one cycle with result_valid high;
// the receiver cannot stall them, and the last result of an item has
// result.last set. The final result shows in the same cycle that busy drops, so
// a new item may be started while it is on the port.
// Each item's microprogram sets how long it keeps busy high; mod runs the
//   shared divider for 16 steps and div for 48; a zero divisor (for mod, a
//   divisor with a zero integer part) ends div or mod before the divider runs;
//   print makes one read and one result per stack entry, and gives no
//   result when the stack is empty.
// The stack sits in a single-port-read memory with registered read data,
// which adds one read step before every pop.
// Reset empties the stack at once (only the entry count is cleared) and
// leaves the block idle; no clearing pass is needed.
module rpn_stack_calculator_core #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rpn_pkg::cmd_t command,
    output logic          result_valid,
    output rpn_pkg::rsp_t result
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int DW = rpn_pkg::DEPTH_W;
    localparam int XW = rpn_pkg::DATA_W;
    localparam int QW = rpn_pkg::DIV_W;
    localparam int IW = rpn_pkg::DIV_ITER_W;
    localparam int PW = rpn_pkg::UPC_W;
    localparam int FW = rpn_pkg::FRAC_W;

    localparam logic signed [XW-1:0] SMAX = {1'b0, {(XW-1){1'b1}}};
    localparam logic signed [XW-1:0] SMIN = {1'b1, {(XW-1){1'b0}}};

    // Sequencer
    logic              busy_reg, busy_next;
    logic [PW-1:0]     upc_reg, upc_next;
    rpn_pkg::uctl_t    ctl;
    logic              take;
    logic              accept;

    // Stack
    logic signed [XW-1:0] stack_mem [STACK_DEPTH];
    logic signed [XW-1:0] rd_data_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        rd_ptr, rd_ptr_m1;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic signed [XW-1:0] mem_wdata;
    logic                 stack_full;

    // Datapath
    logic signed [XW-1:0]   operand_reg, operand_next;
    logic signed [XW-1:0]   a_reg, a_next;
    logic signed [XW-1:0]   b_reg, b_next;
    logic signed [XW-1:0]   acc_reg, acc_next;
    logic signed [2*XW-1:0] prod_reg, prod_next;
    logic [XW-1:0]          rem_reg, rem_next;
    logic [QW-1:0]          quo_reg, quo_next;
    logic [XW-1:0]          dvsr_reg, dvsr_next;
    logic [IW-1:0]          iter_reg, iter_next;
    logic                   neg_reg, neg_next;
    logic                   under_reg, under_next;
    logic                   zdiv_reg, zdiv_next;
    logic                   sat_reg, sat_next;
    logic                   full_reg, full_next;
    logic                   unk_reg, unk_next;
    logic                   result_valid_reg, result_valid_next;
    rpn_pkg::rsp_t          result_reg, result_next;

    logic [XW-1:0]          a_mag, b_mag;
    logic                   b_is_zero, b_int_zero;
    logic signed [XW:0]     sum_w, dif_w;
    logic signed [2*XW-1:0] prod_biased, prod_scaled;
    logic [XW:0]            rem_shift, rem_trial;
    logic [XW-1:0]          mod_mag;
    rpn_pkg::status_t       emit_status;

    assign accept = start && !busy_reg;

    // ------------------------------------------------------------------
    // Microsequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        ctl = rpn_pkg::ucode(upc_reg);
        case (ctl.cond)
            rpn_pkg::C_ZDIV:     take = b_is_zero;
            rpn_pkg::C_ZMOD:     take = b_int_zero;
            rpn_pkg::C_LOOP:     take = (iter_reg != '0);
            rpn_pkg::C_PR_EMPTY: take = (idx_reg == '0);
            rpn_pkg::C_PR_MORE:  take = (idx_reg != CW'(1));
            default:             take = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                upc_next  = rpn_pkg::entry(command.opcode);
            end
        end
        else if (take)
        begin
            upc_next = ctl.target;
        end
        else if (ctl.fin)
        begin
            busy_next = 1'b0;
        end
        else
        begin
            upc_next = upc_reg + PW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Stack memory: one write and one registered read per cycle
    // ------------------------------------------------------------------
    assign rd_ptr     = ctl.rd_idx ? idx_reg : count_reg;
    assign rd_ptr_m1  = rd_ptr - CW'(1);
    assign rd_addr    = rd_ptr_m1[AW-1:0];
    assign stack_full = (count_reg == CW'(STACK_DEPTH));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[count_reg[AW-1:0]] <= mem_wdata;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    assign a_mag      = a_reg[XW-1] ? (~a_reg) + XW'(1) : a_reg;
    assign b_mag      = b_reg[XW-1] ? (~b_reg) + XW'(1) : b_reg;
    assign b_is_zero  = (b_reg == '0);
    assign b_int_zero = (b_mag[XW-1:FW] == '0);

    assign sum_w = {a_reg[XW-1], a_reg} + {b_reg[XW-1], b_reg};
    assign dif_w = {a_reg[XW-1], a_reg} - {b_reg[XW-1], b_reg};

    // Division by 65536 truncates toward zero, so negative products are biased.
    assign prod_biased = prod_reg + (prod_reg[2*XW-1] ? (2*XW)'(65535) : '0);
    assign prod_scaled = prod_biased >>> FW;

    assign rem_shift = {rem_reg, quo_reg[QW-1]};
    assign rem_trial = rem_shift - {1'b0, dvsr_reg};
    assign mod_mag   = {rem_reg[FW-1:0], {FW{1'b0}}};

    always_comb
    begin
        if (under_reg)
            emit_status = rpn_pkg::ST_UNDER;
        else if (zdiv_reg)
            emit_status = rpn_pkg::ST_ZDIV;
        else if (sat_reg)
            emit_status = rpn_pkg::ST_SAT;
        else if (full_reg)
            emit_status = rpn_pkg::ST_FULL;
        else if (unk_reg)
            emit_status = rpn_pkg::ST_UNKNOWN;
        else
            emit_status = rpn_pkg::ST_OK;
    end

    always_comb
    begin
        count_next        = count_reg;
        idx_next          = idx_reg;
        operand_next      = operand_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        acc_next          = acc_reg;
        prod_next         = prod_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        dvsr_next         = dvsr_reg;
        iter_next         = iter_reg;
        neg_next          = neg_reg;
        under_next        = under_reg;
        zdiv_next         = zdiv_reg;
        sat_next          = sat_reg;
        full_next         = full_reg;
        unk_next          = unk_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        mem_we            = 1'b0;
        mem_wdata         = acc_reg;

        if (accept)
        begin
            operand_next = command.operand;
            under_next   = 1'b0;
            zdiv_next    = 1'b0;
            sat_next     = 1'b0;
            full_next    = 1'b0;
            unk_next     = 1'b0;
        end

        if (busy_reg)
        begin
            case (ctl.uop)
                rpn_pkg::U_PUSH_IN:
                begin
                    acc_next = operand_reg;
                    if (stack_full)
                    begin
                        full_next = 1'b1;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = operand_reg;
                        count_next = count_reg + CW'(1);
                    end
                end
                rpn_pkg::U_POP_B:
                begin
                    if (count_reg != '0)
                    begin
                        b_next     = rd_data_reg;
                        count_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        b_next     = '0;
                        under_next = 1'b1;
                    end
                end
                rpn_pkg::U_POP_A:
                begin
                    if (count_reg != '0)
                    begin
                        a_next     = rd_data_reg;
                        count_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        a_next     = '0;
                        under_next = 1'b1;
                    end
                end
                rpn_pkg::U_ADD:
                begin
                    if (sum_w[XW] != sum_w[XW-1])
                    begin
                        acc_next = sum_w[XW] ? SMIN : SMAX;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = sum_w[XW-1:0];
                    end
                end
                rpn_pkg::U_SUB:
                begin
                    if (dif_w[XW] != dif_w[XW-1])
                    begin
                        acc_next = dif_w[XW] ? SMIN : SMAX;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = dif_w[XW-1:0];
                    end
                end
                rpn_pkg::U_MUL:
                begin
                    prod_next = a_reg * b_reg;
                end
                rpn_pkg::U_MUL_SCALE:
                begin
                    if ((prod_scaled[2*XW-1:XW-1] != '0)
                        && (prod_scaled[2*XW-1:XW-1] != '1))
                    begin
                        acc_next = prod_scaled[2*XW-1] ? SMIN : SMAX;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = prod_scaled[XW-1:0];
                    end
                end
                rpn_pkg::U_CHK_DIV:
                begin
                    zdiv_next = b_is_zero;
                end
                rpn_pkg::U_CHK_MOD:
                begin
                    zdiv_next = b_int_zero;
                end
                rpn_pkg::U_DIV_LOAD:
                begin
                    quo_next  = {a_mag, {FW{1'b0}}};
                    dvsr_next = b_mag;
                    rem_next  = '0;
                    iter_next = rpn_pkg::DIV_ITERS_M1;
                    neg_next  = a_reg[XW-1] ^ b_reg[XW-1];
                end
                rpn_pkg::U_MOD_LOAD:
                begin
                    // Only the integer parts take part; the remainder keeps
                    // the sign of the dividend.
                    quo_next  = {a_mag[XW-1:FW], {(QW-XW+FW){1'b0}}};
                    dvsr_next = {{FW{1'b0}}, b_mag[XW-1:FW]};
                    rem_next  = '0;
                    iter_next = rpn_pkg::MOD_ITERS_M1;
                    neg_next  = a_reg[XW-1];
                end
                rpn_pkg::U_DIV_STEP:
                begin
                    iter_next = iter_reg - IW'(1);
                    if (!rem_trial[XW])
                    begin
                        rem_next = rem_trial[XW-1:0];
                        quo_next = {quo_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_shift[XW-1:0];
                        quo_next = {quo_reg[QW-2:0], 1'b0};
                    end
                end
                rpn_pkg::U_DIV_FIX:
                begin
                    if (neg_reg)
                    begin
                        if (quo_reg > {{(QW-XW){1'b0}}, SMIN})
                        begin
                            acc_next = SMIN;
                            sat_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = XW'(0) - quo_reg[XW-1:0];
                        end
                    end
                    else
                    begin
                        if (quo_reg > QW'(SMAX))
                        begin
                            acc_next = SMAX;
                            sat_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = quo_reg[XW-1:0];
                        end
                    end
                end
                rpn_pkg::U_MOD_FIX:
                begin
                    acc_next = neg_reg ? XW'(0) - mod_mag : mod_mag;
                end
                rpn_pkg::U_PUSH_RES:
                begin
                    if (!stack_full)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                rpn_pkg::U_MOV_B:
                begin
                    acc_next = b_reg;
                end
                rpn_pkg::U_UNKNOWN:
                begin
                    acc_next = '0;
                    unk_next = 1'b1;
                end
                rpn_pkg::U_EMIT:
                begin
                    result_valid_next  = 1'b1;
                    result_next.value  = zdiv_reg ? '0 : acc_reg;
                    result_next.status = emit_status;
                    result_next.depth  = DW'(count_reg);
                    result_next.last   = 1'b1;
                end
                rpn_pkg::U_PR_LOAD:
                begin
                    idx_next = count_reg;
                end
                rpn_pkg::U_PR_EMIT:
                begin
                    result_valid_next  = 1'b1;
                    result_next.value  = rd_data_reg;
                    result_next.status = rpn_pkg::ST_OK;
                    result_next.depth  = DW'(count_reg);
                    result_next.last   = (idx_reg == CW'(1));
                    idx_next           = idx_reg - CW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            upc_reg          <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg         <= busy_next;
            upc_reg          <= upc_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        operand_reg <= operand_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dvsr_reg    <= dvsr_next;
        iter_reg    <= iter_next;
        neg_reg     <= neg_next;
        under_reg   <= under_next;
        zdiv_reg    <= zdiv_next;
        sat_reg     <= sat_next;
        full_reg    <= full_next;
        unk_reg     <= unk_next;
        result_reg  <= result_next;
    end

    assign busy         = busy_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond stack depth");

    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> $past(busy_reg))
        else $error("result strobe without an item in progress");

    a_result_depth: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.depth == DW'(count_reg)))
        else $error("reported depth differs from stack count");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (ctl.uop == rpn_pkg::U_DIV_STEP)) |-> (dvsr_reg != '0))
        else $error("divider running with a zero divisor");

endmodule
